FILE: src/dotq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared types and codes of the deadline ordered task queue: action and
// status codes, the stored task record and the default queue depth.
// ----------------------------------------------------------------------------
package dotq_pkg;

  // Default number of task slots
  localparam int unsigned DEPTH_DEF = 16;

  // Action codes of an input beat
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // Status codes of a result beat
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // One queued task as held in a slot
  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] ident;
    logic        kind;
    logic [31:0] handle;
  } entry_t;

endpackage

FILE: src/dotq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No reset on the contents.
// ----------------------------------------------------------------------------
module dotq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/deadline_ordered_task_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_ordered_task_queue
// Earliest-deadline-first ready queue kept as a sorted array in one RAM.
// ----------------------------------------------------------------------------
// A beat is taken when start_i is high and busy_o is low; its single result
// is registered as the operation ends and shows for exactly one cycle with
// done_o high, and cannot be held off by the receiver. Tasks live in one
// slot RAM (registered read, one read and one write a cycle) in ascending
// deadline order, slot 0 the head. The RAM port sets the timing: an insert
// walks from the tail toward its place, moving one slot a cycle, and writes
// the new task above the first slot that stays, or into the head slot in a
// final head step; a remove walks the whole queue; a peek reads the head
// slot. An insert into a full or empty queue, a remove or peek on an empty
// queue, and action code 3 finish in the idle state without a walk.
// occupancy_o is the task count after the reported operation.
// ----------------------------------------------------------------------------
module deadline_ordered_task_queue #(
  parameter int unsigned DEPTH = dotq_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] task_ident_i,
  input  logic [31:0] deadline_i,
  input  logic        task_kind_i,
  input  logic [31:0] handle_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] head_ident_o,
  output logic [31:0] head_deadline_o,
  output logic        head_kind_o,
  output logic [31:0] head_handle_o,
  output logic [4:0]  occupancy_o
);

  import dotq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_PEEK = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          found_q, found_d;
  logic [CW-1:0] count_q, count_d;
  logic          done_q, done_d;
  status_e       status_q, status_d;
  entry_t        head_q, head_d;
  entry_t        item_q, item_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  entry_t        in_entry;
  logic          move;
  logic          last;
  logic          hit;
  logic [31:0]   count_ext;

  // Slot storage
  dotq_ram #(
    .Width ($bits(entry_t)),
    .Depth (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_entry = '{deadline: deadline_i, ident: task_ident_i,
                      kind: task_kind_i, handle: handle_i};

  // Insert: does the slot under the pointer move one place toward the tail
  assign move = (ptr_q == '0) ? (ram_rdata.deadline > item_q.deadline)
                              : (ram_rdata.deadline >= item_q.deadline);
  // Remove: last occupied slot reached, identifier match
  assign last = (CW'(ptr_q) == (count_q - CW'(1)));
  assign hit  = (ram_rdata.ident == item_q.ident);

  // Sequence the read-modify-write walks over the slot RAM
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    found_d   = found_q;
    count_d   = count_q;
    done_d    = 1'b0;
    status_d  = status_q;
    head_d    = head_q;
    item_d    = item_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q + AW'(1);
    ram_wdata = item_q;
    ram_raddr = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d   = in_entry;
          head_d   = '0;
          status_d = ST_OK;
          unique case (action_e'(action_i))
            ACT_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
              end else if (count_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_entry;
                count_d   = count_q + CW'(1);
                done_d    = 1'b1;
              end else begin
                ptr_d     = AW'(count_q - CW'(1));
                ram_raddr = AW'(count_q - CW'(1));
                state_d   = S_INS;
              end
            end
            ACT_REMOVE: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_NOTFOUND;
              end else begin
                ptr_d     = '0;
                ram_raddr = '0;
                found_d   = 1'b0;
                state_d   = S_REM;
              end
            end
            ACT_PEEK: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                ram_raddr = '0;
                state_d   = S_PEEK;
              end
            end
            ACT_NOP: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // read the next slot down while deciding on this one
        ram_raddr = ptr_q - AW'(1);
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AW'(1);
        if (move) begin
          ram_wdata = ram_rdata;
          if (ptr_q == '0) begin
            state_d = S_HEAD;
          end else begin
            ptr_d = ptr_q - AW'(1);
          end
        end else begin
          ram_wdata = item_q;
          count_d   = count_q + CW'(1);
          done_d    = 1'b1;
          status_d  = ST_OK;
          state_d   = S_IDLE;
        end
      end

      S_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = item_q;
        count_d   = count_q + CW'(1);
        done_d    = 1'b1;
        status_d  = ST_OK;
        state_d   = S_IDLE;
      end

      S_REM: begin
        // read ahead; after the match, pull each slot down by one
        ram_raddr = ptr_q + AW'(1);
        ram_waddr = ptr_q - AW'(1);
        ram_wdata = ram_rdata;
        if (found_q) begin
          ram_we = 1'b1;
        end else if (hit) begin
          found_d = 1'b1;
        end
        if (last) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (found_q || hit) begin
            count_d  = count_q - CW'(1);
            status_d = ST_OK;
          end else begin
            status_d = ST_NOTFOUND;
          end
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end

      S_PEEK: begin
        head_d   = ram_rdata;
        status_d = ST_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      found_q <= 1'b0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      found_q <= found_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Payload: latched beat and result fields
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    status_q <= status_d;
    head_q   <= head_d;
  end

  assign count_ext       = 32'(count_q);
  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign head_ident_o    = head_q.ident;
  assign head_deadline_o = head_q.deadline;
  assign head_kind_o     = head_q.kind;
  assign head_handle_o   = head_q.handle;
  assign occupancy_o     = count_ext[4:0];

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("task count above queue depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result beat while a walk is still running");

  a_count_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_q)
    else $error("task count changed without a result beat");

  a_ins_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS || state_q == S_REM) |-> (CW'(ptr_q) < count_q))
    else $error("walk pointer beyond occupied slots");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> (count_q == CW'(DEPTH)))
    else $error("full status reported on a queue that is not full");
`endif

endmodule
